// File: rtl/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// Constants for the zobrist position hash: key table layout and the
// splitmix64 generator constants.
// ----------------------------------------------------------------------------
package zph_pkg;

  localparam int BOARD_SQUARES = 64;
  localparam int PIECE_KINDS   = 12;
  localparam int CASTLE_KEYS   = 16;
  localparam int EP_KEYS       = 8;

  localparam int PS_DEPTH    = PIECE_KINDS * BOARD_SQUARES;
  localparam int CASTLE_BASE = PS_DEPTH;
  localparam int EP_BASE     = CASTLE_BASE + CASTLE_KEYS;
  localparam int SIDE_KEY    = EP_BASE + EP_KEYS;
  localparam int TABLE_DEPTH = SIDE_KEY + 1;

  localparam int PS_ADDR_W = $clog2(PS_DEPTH);
  localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CASTLE_W  = $clog2(CASTLE_KEYS);
  localparam int EP_W      = $clog2(EP_KEYS);

  localparam logic [63:0] SEED_RESET  = 64'h1123581321345589;
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_ONE     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_TWO     = 64'h94d049bb133111eb;

  localparam logic KIND_SQUARE = 1'b0;
  localparam logic KIND_CLOSE  = 1'b1;

endpackage

// File: rtl/zobrist_position_hash.sv
// ----------------------------------------------------------------------------
// zobrist_position_hash
// Zobrist hash of a chess position from a splitmix64-generated key table.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_ready. A square item (kind 0) xors the
// key of its piece on its square into a 64-bit accumulator; empty squares
// and piece codes above 12 add nothing. A closing item (kind 1) xors the
// side-to-move, castling and en-passant keys, sends the hash out on
// out_valid/out_ready and clears the accumulator.
// Throughput is one item per cycle when not filling and not stalled: each
// square item makes one read of the piece-square key memory, whose single
// read port sets the rate. A closing item goes through stage b to the output
// register. The output register lets square items keep flowing while a hash
// waits; only a second closing item stalls behind an unread hash.
// After reset and after every seed write the key table is regenerated:
// splitmix64 runs through a 3-stage multiply pipeline, one key per cycle,
// so in_ready stays low until all 793 keys are written.
// A seed write also clears the accumulator.
// ----------------------------------------------------------------------------
module zobrist_position_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [63:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [5:0]  square,
  input  logic [3:0]  piece_code,
  input  logic        black_to_move,
  input  logic [3:0]  castling_rights,
  input  logic        ep_valid,
  input  logic [2:0]  ep_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] position_hash
);
  import zph_pkg::*;

  // ---------------- key generation pipeline ----------------
  logic [FILL_W-1:0] fill_cnt;
  logic [63:0]       gen_state;
  logic              issue;
  logic [63:0]       z0, s1;
  logic [63:0]       mul1_lo;
  logic [31:0]       mul1_cross;

  logic              g1_v;
  logic [FILL_W-1:0] g1_idx;
  logic [63:0]       g1_lo;
  logic [31:0]       g1_cross;
  logic [63:0]       y1, s2;
  logic [63:0]       mul2_lo;
  logic [31:0]       mul2_cross;

  logic              g2_v;
  logic [FILL_W-1:0] g2_idx;
  logic [63:0]       g2_lo;
  logic [31:0]       g2_cross;
  logic [63:0]       y2, new_key;
  logic [FILL_W-1:0] castle_off, ep_off;

  logic              filling;

  assign issue = (fill_cnt != FILL_W'(TABLE_DEPTH));
  assign z0    = gen_state + GOLDEN_STEP;
  assign s1    = z0 ^ (z0 >> 30);

  // 64x64 low product split into 32x32 partial products
  assign mul1_lo    = 64'(s1[31:0]) * 64'(MIX_ONE[31:0]);
  assign mul1_cross = s1[63:32] * MIX_ONE[31:0] + s1[31:0] * MIX_ONE[63:32];

  assign y1         = g1_lo + {g1_cross, 32'd0};
  assign s2         = y1 ^ (y1 >> 27);
  assign mul2_lo    = 64'(s2[31:0]) * 64'(MIX_TWO[31:0]);
  assign mul2_cross = s2[63:32] * MIX_TWO[31:0] + s2[31:0] * MIX_TWO[63:32];

  assign y2      = g2_lo + {g2_cross, 32'd0};
  assign new_key = y2 ^ (y2 >> 31);

  assign castle_off = g2_idx - FILL_W'(CASTLE_BASE);
  assign ep_off     = g2_idx - FILL_W'(EP_BASE);

  assign filling = issue || g1_v || g2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt  <= '0;
      gen_state <= SEED_RESET;
      g1_v      <= 1'b0;
      g2_v      <= 1'b0;
    end else if (cfg_write_en) begin
      fill_cnt  <= '0;
      gen_state <= cfg_write_data;
      g1_v      <= 1'b0;
      g2_v      <= 1'b0;
    end else begin
      g1_v <= issue;
      g2_v <= g1_v;
      if (issue) begin
        fill_cnt  <= fill_cnt + FILL_W'(1);
        gen_state <= z0;
      end
    end
  end

  always_ff @(posedge clk) begin
    g1_idx   <= fill_cnt;
    g1_lo    <= mul1_lo;
    g1_cross <= mul1_cross;
    g2_idx   <= g1_idx;
    g2_lo    <= mul2_lo;
    g2_cross <= mul2_cross;
  end

  // ---------------- key storage ----------------
  logic [63:0]          ps_mem [PS_DEPTH];
  logic [63:0]          castle_key [CASTLE_KEYS];
  logic [63:0]          ep_key [EP_KEYS];
  logic [63:0]          side_key;
  logic [PS_ADDR_W-1:0] rd_addr;
  logic                 rd_en;
  logic [63:0]          rd_data;

  always_ff @(posedge clk) begin
    if (g2_v && (g2_idx < FILL_W'(PS_DEPTH))) begin
      ps_mem[g2_idx[PS_ADDR_W-1:0]] <= new_key;
    end
    if (rd_en) begin
      rd_data <= ps_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (g2_v) begin
      if ((g2_idx >= FILL_W'(CASTLE_BASE)) && (g2_idx < FILL_W'(EP_BASE))) begin
        castle_key[castle_off[CASTLE_W-1:0]] <= new_key;
      end
      if ((g2_idx >= FILL_W'(EP_BASE)) && (g2_idx < FILL_W'(SIDE_KEY))) begin
        ep_key[ep_off[EP_W-1:0]] <= new_key;
      end
      if (g2_idx == FILL_W'(SIDE_KEY)) begin
        side_key <= new_key;
      end
    end
  end

  // ---------------- item pipeline ----------------
  logic        accept;
  logic        sq_hit;
  logic [3:0]  piece_idx;
  logic [63:0] flag_keys;
  logic        b_valid;
  logic        b_close;
  logic        b_hit;
  logic [63:0] b_flags;
  logic        b_stall;
  logic [63:0] acc;

  assign sq_hit    = (piece_code >= 4'd1) && (piece_code <= 4'(PIECE_KINDS));
  assign piece_idx = piece_code - 4'd1;
  assign rd_addr   = PS_ADDR_W'(piece_idx) * PS_ADDR_W'(BOARD_SQUARES)
                   + PS_ADDR_W'(square);

  assign flag_keys = (black_to_move ? side_key : 64'd0)
                   ^ castle_key[castling_rights]
                   ^ (ep_valid ? ep_key[ep_file] : 64'd0);

  // a closing item waits in stage b while an earlier hash is unread
  assign b_stall  = b_valid && b_close && out_valid && !out_ready;
  assign in_ready = !filling && !b_stall;
  assign accept   = in_valid && in_ready;
  assign rd_en    = accept && (kind == KIND_SQUARE) && sq_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (!b_stall) begin
        b_valid <= accept;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (b_valid && !b_stall) begin
        if (b_close) begin
          out_valid <= 1'b1;
          acc       <= '0;
        end else if (b_hit) begin
          acc <= acc ^ rd_data;
        end
      end
      if (cfg_write_en) begin
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_close <= (kind == KIND_CLOSE);
      b_hit   <= sq_hit;
      b_flags <= flag_keys;
    end
    if (b_valid && b_close && !b_stall) begin
      position_hash <= acc ^ b_flags;
    end
  end

  // ---------------- assertions ----------------
  a_no_accept_while_filling: assert property (@(posedge clk) disable iff (rst)
    filling |-> !in_ready)
    else $error("item accepted during key table fill");

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> filling)
    else $error("seed write did not restart the fill");

  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_valid && b_close))
    else $error("hash emitted without a closing item");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_close && !b_stall) |=> (acc == 64'd0))
    else $error("accumulator not cleared after a closing item");

endmodule

// File: sim/tb_zobrist_position_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zobrist_position_hash
// Self-checking bench for the zobrist position hash. Positions stream in as
// square items and a closing item. A local splitmix64 key table and
// accumulator predict every hash, and each hash that leaves the block is
// checked against the oldest one predicted. Several seeds are written, among
// them zero and all ones, with random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_zobrist_position_hash;
  import zph_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  // long enough to outlast the key table fill and then back up the block
  localparam int HOLD_CYCLES  = 1000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 80;

  typedef struct packed {
    logic       kind;
    logic [5:0] square;
    logic [3:0] piece_code;
    logic       black_to_move;
    logic [3:0] castling_rights;
    logic       ep_valid;
    logic [2:0] ep_file;
  } pos_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [63:0] cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [5:0]  square;
  logic [3:0]  piece_code;
  logic        black_to_move;
  logic [3:0]  castling_rights;
  logic        ep_valid;
  logic [2:0]  ep_file;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] position_hash;

  zobrist_position_hash u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .square          (square),
    .piece_code      (piece_code),
    .black_to_move   (black_to_move),
    .castling_rights (castling_rights),
    .ep_valid        (ep_valid),
    .ep_file         (ep_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .position_hash   (position_hash)
  );

  // local copy of the key table and running position hash
  logic [63:0] key_words [TABLE_DEPTH];
  logic [63:0] position_acc;

  pos_item_t   pending_items[$];
  logic [63:0] expected_hashes[$];

  pos_item_t next_item;
  logic      in_fire;
  logic      no_idle;
  logic      hold_request;
  int        hold_left;
  int        failures;
  int        n_items;
  int        n_hashes;
  int        n_seeds;
  int        n_queued;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void build_key_words(logic [63:0] seed);
    logic [63:0] gen;
    logic [63:0] z;
    gen = seed;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      gen = gen + GOLDEN_STEP;
      z = gen;
      z = (z ^ (z >> 30)) * MIX_ONE;
      z = (z ^ (z >> 27)) * MIX_TWO;
      key_words[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic void apply_item_to_hash(pos_item_t it);
    logic [63:0] h;
    if (it.kind == KIND_SQUARE) begin
      if (it.piece_code >= 1 && it.piece_code <= PIECE_KINDS)
        position_acc ^= key_words[(int'(it.piece_code) - 1) * BOARD_SQUARES +
                                  int'(it.square)];
    end else begin
      h = position_acc;
      if (it.black_to_move)
        h ^= key_words[SIDE_KEY];
      h ^= key_words[CASTLE_BASE + int'(it.castling_rights)];
      if (it.ep_valid)
        h ^= key_words[EP_BASE + int'(it.ep_file)];
      expected_hashes.push_back(h);
      position_acc = '0;
    end
  endfunction

  function automatic pos_item_t random_item();
    pos_item_t   it;
    logic [31:0] r;
    r  = $urandom;
    it = r[$bits(pos_item_t)-1:0];
    return it;
  endfunction

  task automatic add_item(logic k, logic [5:0] sq, logic [3:0] pc, logic btm,
                          logic [3:0] cr, logic epv, logic [2:0] epf);
    pos_item_t it;
    it.kind            = k;
    it.square          = sq;
    it.piece_code      = pc;
    it.black_to_move   = btm;
    it.castling_rights = cr;
    it.ep_valid        = epv;
    it.ep_file         = epf;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // square items with random content, then a closing item
  task automatic add_position();
    pos_item_t it;
    int        n;
    n = ($urandom_range(99) < 10) ? $urandom_range(25, 40) : $urandom_range(0, 16);
    for (int i = 0; i < n; i++) begin
      it = random_item();
      it.kind = KIND_SQUARE;
      if ($urandom_range(99) < 85)
        it.piece_code = 4'($urandom_range(1, PIECE_KINDS));
      pending_items.push_back(it);
    end
    it = random_item();
    it.kind = KIND_CLOSE;
    pending_items.push_back(it);
    n_queued += n + 1;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_hashes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] seed);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= seed;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    build_key_words(seed);
    position_acc = '0;
    n_seeds++;
  endtask

  // input handshake and prediction
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      apply_item_to_hash({kind, square, piece_code, black_to_move,
                          castling_rights, ep_valid, ep_file});
      n_items++;
    end
  end

  // driver: an offered item is held until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 29)) begin
      next_item       = pending_items.pop_front();
      kind            <= next_item.kind;
      square          <= next_item.square;
      piece_code      <= next_item.piece_code;
      black_to_move   <= next_item.black_to_move;
      castling_rights <= next_item.castling_rights;
      ep_valid        <= next_item.ep_valid;
      ep_file         <= next_item.ep_file;
      in_valid        <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $error("position_hash: expected none, actual %h", position_hash);
        failures++;
      end else begin
        if (position_hash !== expected_hashes[0]) begin
          $error("position_hash: expected %h, actual %h", expected_hashes[0],
                 position_hash);
          failures++;
        end
        void'(expected_hashes.pop_front());
        n_hashes++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d hashes outstanding", expected_hashes.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [63:0] phase_seed;
    rst             = 1'b1;
    cfg_write_en    = 1'b0;
    cfg_write_data  = '0;
    in_valid        = 1'b0;
    kind            = KIND_SQUARE;
    square          = '0;
    piece_code      = '0;
    black_to_move   = 1'b0;
    castling_rights = '0;
    ep_valid        = 1'b0;
    ep_file         = '0;
    in_fire         = 1'b0;
    no_idle         = 1'b0;
    hold_request    = 1'b0;
    hold_left       = 0;
    failures        = 0;
    n_items         = 0;
    n_hashes        = 0;
    n_seeds         = 0;
    n_queued        = 0;
    build_key_words(SEED_RESET);
    position_acc = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty board, all flags, corner squares, odd piece codes
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_CLOSE,  6'd63, 4'd15, 1'b1, 4'd15, 1'b1, 3'd7);
    add_item(KIND_SQUARE, 6'd0,  4'd1,  1'b1, 4'd15, 1'b1, 3'd7);
    add_item(KIND_SQUARE, 6'd63, 4'd12, 1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd63, 4'd6,  1'b1, 4'd9,  1'b0, 3'd2);
    add_item(KIND_SQUARE, 6'd7,  4'd0,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd8,  4'd13, 1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd9,  4'd14, 1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd10, 4'd15, 1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b0, 4'd5,  1'b0, 3'd5);
    // same key twice cancels out
    add_item(KIND_SQUARE, 6'd28, 4'd7,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd28, 4'd7,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b1, 4'd0,  1'b1, 3'd0);
    // seed write in the middle of a position drops the partial hash
    add_item(KIND_SQUARE, 6'd12, 4'd3,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_SQUARE, 6'd40, 4'd9,  1'b0, 4'd0,  1'b0, 3'd0);
    wait_idle();
    write_seed(64'h0);
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b0, 4'd10, 1'b1, 3'd3);
    add_item(KIND_SQUARE, 6'd63, 4'd12, 1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b1, 4'd15, 1'b1, 3'd7);
    wait_idle();
    write_seed('1);
    add_item(KIND_SQUARE, 6'd0,  4'd1,  1'b0, 4'd0,  1'b0, 3'd0);
    add_item(KIND_CLOSE,  6'd0,  4'd0,  1'b0, 4'd0,  1'b0, 3'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       phase_seed = SEED_RESET;
        1:       phase_seed = 64'h0;
        2:       phase_seed = '1;
        default: phase_seed = {$urandom, $urandom};
      endcase
      write_seed(phase_seed);
      no_idle = (p == 3);
      n_queued = 0;
      while (n_queued < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          add_position();
        end else begin
          pending_items.push_back(random_item());
          n_queued++;
        end
        // sender stops until every hash is back, then resumes
        if (p == 4 && n_queued >= PHASE_ITEMS / 2 && n_queued < PHASE_ITEMS / 2 + 20)
          wait_idle();
      end
      // long receiver stall while closing items keep coming
      if (p == 2)
        hold_request = 1'b1;
    end

    wait_idle();
    no_idle = 1'b0;
    $display("%0d items in, %0d hashes checked, %0d key seeds (zero, all ones, random)",
             n_items, n_hashes, n_seeds);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", failures);
      $display("FAIL");
    end
    $finish;
  end

endmodule
